// ===== rtl/mkce_pkg.sv =====
package mkce_pkg;

    localparam int unsigned KEYS_N      = 16;
    localparam int unsigned KEY_W       = 4;
    localparam int unsigned CODE_LEN    = 4;
    localparam int unsigned ENTERED_W   = 2;
    localparam int unsigned DEBOUNCE_W  = 10;
    localparam int unsigned TIMEOUT_W   = 16;
    localparam int unsigned TIMER_W     = 17;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [DEBOUNCE_W-1:0] COUNT_MAX         = '1;
    localparam logic [TIMER_W-1:0]    TIMER_MAX         = '1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET    = DEBOUNCE_W'(40);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET     = TIMEOUT_W'(5000);
    localparam logic [ENTERED_W-1:0]  LAST_KEY_SLOT     = ENTERED_W'(CODE_LEN - 1);

    localparam logic [CFG_IDX_W-1:0]  REG_DEBOUNCE_MS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  REG_TIMEOUT_MS    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MODE_SCANNING = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_HOLD     = 2'd2
    } t_scan_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_COMPLETE = 2'd1,
        STATUS_TIMEOUT  = 2'd2
    } t_code_status;

    typedef logic [KEY_W-1:0] t_key;

endpackage

// ===== rtl/mkce_in_if.sv =====
interface mkce_in_if;
    logic                               valid;
    logic                               ready;
    logic [mkce_pkg::KEYS_N-1:0]        pressed_keys;

    modport source (output valid, output pressed_keys, input ready);
    modport sink   (input valid, input pressed_keys, output ready);
endinterface

// ===== rtl/mkce_out_if.sv =====
interface mkce_out_if;
    logic                               valid;
    logic                               ready;
    logic [mkce_pkg::STATUS_W-1:0]      code_status;
    logic [mkce_pkg::KEY_W-1:0]         first_key;
    logic [mkce_pkg::KEY_W-1:0]         second_key;
    logic [mkce_pkg::KEY_W-1:0]         third_key;
    logic [mkce_pkg::KEY_W-1:0]         fourth_key;

    modport source (output valid, output code_status, output first_key, output second_key,
                    output third_key, output fourth_key, input ready);
    modport sink   (input valid, input code_status, input first_key, input second_key,
                    input third_key, input fourth_key, output ready);
endinterface

// ===== rtl/matrix_keypad_code_entry.sv =====
// Channel   Direction  Payload
// i_in      in         pressed_keys (16 bit snapshot, one per tick)
// o_out     out        code_status, first_key, second_key, third_key, fourth_key
// i_cfg_*   in         register write: debounce_ms (index 0), timeout_ms (index 1)
//
// Every accepted snapshot yields exactly one result, registered and shown in the next cycle.
// A new snapshot is taken in every cycle while the result register is empty or
// its transfer completes in that cycle, so the sustained rate is one item per clock.
// Synchronous active-low reset clears the keypad machine, the code timer and the
// output valid, and loads the register defaults of 40 and 5000 ticks.
// A stalled result holds its register and blocks new input until it is taken.
module matrix_keypad_code_entry (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mkce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkce_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mkce_in_if.sink                           i_in,
    mkce_out_if.source                        o_out
);
    import mkce_pkg::*;

    logic [DEBOUNCE_W-1:0] r_debounce_ms;
    logic [TIMEOUT_W-1:0]  r_timeout_ms;

    t_scan_mode            r_mode, n_mode;
    t_key                  r_candidate, n_candidate;
    logic [DEBOUNCE_W-1:0] r_count, n_count;
    logic [ENTERED_W-1:0]  r_keys_entered, n_keys_entered;
    logic [TIMER_W-1:0]    r_timer, n_timer;
    logic                  r_running, n_running;
    t_key                  r_code_store [CODE_LEN];

    logic                  r_out_valid;
    t_code_status          r_out_status, n_out_status;
    t_key                  r_out_keys [CODE_LEN];
    t_key                  n_out_keys [CODE_LEN];

    logic                  w_in_xfer;
    logic                  w_hit;
    t_key                  w_key;
    logic [DEBOUNCE_W-1:0] w_count_inc;
    logic                  w_release;
    logic [TIMER_W-1:0]    w_timer_tick;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    always_comb begin
        w_hit = 1'b0;
        w_key = '0;
        for (int i = KEYS_N - 1; i >= 0; i--) begin
            if (i_in.pressed_keys[i]) begin
                w_hit = 1'b1;
                w_key = KEY_W'(i);
            end
        end
    end

    assign w_count_inc = (r_count < COUNT_MAX) ? r_count + DEBOUNCE_W'(1) : r_count;

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_SCANNING: begin
                if (w_hit) begin
                    n_mode = MODE_DEBOUNCE;
                end
            end
            MODE_DEBOUNCE: begin
                if (w_count_inc >= r_debounce_ms) begin
                    n_mode = (w_hit && w_key == r_candidate) ? MODE_HOLD : MODE_SCANNING;
                end
            end
            MODE_HOLD: begin
                if (!w_hit || w_key != r_candidate) begin
                    n_mode = MODE_SCANNING;
                end
            end
            default: begin
                n_mode = MODE_SCANNING;
            end
        endcase
    end

    always_comb begin
        n_candidate    = r_candidate;
        n_count        = r_count;
        w_release      = 1'b0;
        n_keys_entered = r_keys_entered;
        n_running      = r_running;
        n_out_status   = STATUS_NONE;
        for (int j = 0; j < CODE_LEN; j++) begin
            n_out_keys[j] = '0;
        end

        if (r_mode == MODE_SCANNING && w_hit) begin
            n_candidate = w_key;
            n_count     = '0;
        end else if (r_mode == MODE_DEBOUNCE) begin
            n_count = w_count_inc;
        end
        w_release = (r_mode == MODE_HOLD) && !w_hit;

        w_timer_tick = (r_running && r_timer < TIMER_MAX) ? r_timer + TIMER_W'(1) : r_timer;
        n_timer      = w_timer_tick;

        if (w_release && r_keys_entered == LAST_KEY_SLOT) begin
            n_running      = 1'b0;
            n_timer        = '0;
            n_keys_entered = '0;
            n_out_status   = STATUS_COMPLETE;
            for (int j = 0; j < CODE_LEN - 1; j++) begin
                n_out_keys[j] = r_code_store[j];
            end
            n_out_keys[CODE_LEN-1] = r_candidate;
        end else begin
            if (w_release) begin
                n_keys_entered = r_keys_entered + ENTERED_W'(1);
                if (r_keys_entered == '0) begin
                    n_running = 1'b1;
                end
            end
            if (w_timer_tick > {1'b0, r_timeout_ms}) begin
                n_keys_entered = '0;
                n_running      = 1'b0;
                n_timer        = '0;
                n_out_status   = STATUS_TIMEOUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_timeout_ms  <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_TIMEOUT_MS:  r_timeout_ms  <= i_cfg_data[TIMEOUT_W-1:0];
                default:         r_timeout_ms  <= r_timeout_ms;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_SCANNING;
            r_candidate    <= '0;
            r_count        <= '0;
            r_keys_entered <= '0;
            r_timer        <= '0;
            r_running      <= 1'b0;
        end else if (w_in_xfer) begin
            r_mode         <= n_mode;
            r_candidate    <= n_candidate;
            r_count        <= n_count;
            r_keys_entered <= n_keys_entered;
            r_timer        <= n_timer;
            r_running      <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_release) begin
            r_code_store[r_keys_entered] <= r_candidate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_status <= n_out_status;
            r_out_keys   <= n_out_keys;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.code_status = r_out_status;
    assign o_out.first_key   = r_out_keys[0];
    assign o_out.second_key  = r_out_keys[1];
    assign o_out.third_key   = r_out_keys[2];
    assign o_out.fourth_key  = r_out_keys[3];

`ifndef SYNTHESIS
    a_keys_zero_unless_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STATUS_COMPLETE) |->
        (r_out_keys[0] == '0 && r_out_keys[1] == '0 && r_out_keys[2] == '0 &&
         r_out_keys[3] == '0))
        else $error("key fields set on a result that is not a complete code");

    a_timer_cleared_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_timer == '0))
        else $error("code timer holds a count while stopped");

    a_complete_restarts_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && n_out_status == STATUS_COMPLETE) |=>
        (r_keys_entered == '0 && !r_running))
        else $error("code entry not restarted after a complete code");

    a_no_accept_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_in_xfer)
        else $error("snapshot taken while the result register is stalled");
`endif

endmodule
